>>> src/pts_pkg.sv
// Package for the per-pixel trim search engine: sizes, register indexes,
// payload structs and the per-pixel state entry type.
// No dependencies; used by pixel_trim_successive_approx_top.
package pts_pkg;

	localparam int PIXELS         = 65536;
	localparam int MAX_TRIM_CODES = 32;
	localparam int IDX_W          = $clog2(PIXELS);
	localparam int CNT_W          = 6;
	localparam int TRIM_W         = 5;
	localparam int OCC_W          = 16;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 16;

	localparam logic [OCC_W-1:0] OCC_HALF = OCC_W'(16384);
	localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(32768);
	localparam logic [OCC_W-1:0] OCC_ZERO = '0;

	localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(2);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TRIM_CODES);

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET    = 2'd0,
		REG_TRIM_CNT  = 2'd1,
		REG_STEP_MODE = 2'd2
	} cfg_reg_t;

	// command codes
	typedef enum logic {
		CMD_START   = 1'b0,
		CMD_MEASURE = 1'b1
	} cmd_t;

	typedef struct packed {
		logic              cmd;
		logic [15:0]       pixel_addr;
		logic [TRIM_W-1:0] start_trim;
		logic [OCC_W-1:0]  occupancy;
	} in_item_t;

	typedef struct packed {
		logic [15:0]       out_pixel_addr;
		logic [TRIM_W-1:0] next_trim;
		logic [TRIM_W-1:0] best_trim;
	} out_item_t;

	// one pixel's search state, one memory word
	typedef struct packed {
		logic [CNT_W-1:0]  window_low;
		logic [CNT_W-1:0]  window_high;
		logic [TRIM_W-1:0] current_trim;
		logic [TRIM_W-1:0] best_code;
		logic [OCC_W-1:0]  best_occupancy;
	} pix_state_t;

endpackage

>>> src/pixel_trim_successive_approx_top.sv
// Per-pixel trim search engine: reads a pixel's search state from one
// synchronous memory, updates it and writes it back. Depends on pts_pkg.
// The state is read into a register on transfer, stage 1 updates it and
// the output register holds the result. Throughput: one item per cycle
// unless the output stalls; the read-modify-write runs in one stage with
// the last write forwarded, so back-to-back items on one pixel are fine.
// Reset clears the pipeline valids and loads the configuration defaults;
// the state memory is not cleared, a pixel's state is defined once started.
module pixel_trim_successive_approx_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pts_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [pts_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  pts_pkg::in_item_t                in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output pts_pkg::out_item_t               out_data
);
	import pts_pkg::*;

	logic [OCC_W-1:0]  target_q;
	logic [CNT_W-1:0]  trim_cnt_q;
	logic              step_mode_q;

	logic              s1_valid;
	in_item_t          item_s1;
	logic              s1_adv;

	pix_state_t        mem [PIXELS];
	pix_state_t        rd_q;
	logic [IDX_W-1:0]  rd_idx;
	logic [IDX_W-1:0]  idx_s1;

	logic              fwd_valid_q;
	logic [IDX_W-1:0]  fwd_idx_q;
	pix_state_t        fwd_data_q;

	pix_state_t        old_st;
	pix_state_t        new_st;
	logic              accept;

	logic [CNT_W-1:0]  cnt;
	logic [CNT_W-1:0]  cnt_m1;
	logic [TRIM_W-1:0] strim_sat;
	logic              below;
	logic [OCC_W-1:0]  dist_new;
	logic [OCC_W-1:0]  dist_best;
	logic [CNT_W-1:0]  wl_new;
	logic [CNT_W-1:0]  wh_new;
	logic [CNT_W:0]    win_sum;
	logic [CNT_W-1:0]  nxt;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= OCC_HALF;
			trim_cnt_q  <= CNT_MAX;
			step_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_TARGET:    target_q    <= cfg_wdata[OCC_W-1:0];
				REG_TRIM_CNT:  trim_cnt_q  <= cfg_wdata[CNT_W-1:0];
				REG_STEP_MODE: step_mode_q <= cfg_wdata[0];
				default:       ;
			endcase
		end
	end

	// handshake: stage 1 moves when the output register is free
	assign s1_adv   = !out_valid || out_ready;
	assign in_ready = !s1_valid || s1_adv;
	assign accept   = in_valid && in_ready;
	assign rd_idx   = in_data.pixel_addr[IDX_W-1:0];
	assign idx_s1   = item_s1.pixel_addr[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_ready) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
	end

	// state memory: read on transfer, write when stage 1 retires
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= mem[rd_idx];
		end
		if (s1_valid && s1_adv) begin
			mem[idx_s1] <= new_st;
		end
	end

	// hold the last write so a read issued on the same edge sees it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (s1_valid && s1_adv) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid && s1_adv) begin
			fwd_idx_q  <= idx_s1;
			fwd_data_q <= new_st;
		end
	end

	assign old_st = (fwd_valid_q && fwd_idx_q == idx_s1) ? fwd_data_q : rd_q;

	// effective trim count, clamped to the supported range
	always_comb begin
		if (trim_cnt_q < CNT_MIN) begin
			cnt = CNT_MIN;
		end else if (trim_cnt_q > CNT_MAX) begin
			cnt = CNT_MAX;
		end else begin
			cnt = trim_cnt_q;
		end
		cnt_m1 = cnt - CNT_W'(1);
	end

	// update the pixel state
	always_comb begin
		below     = item_s1.occupancy < target_q;
		dist_new  = below ? target_q - item_s1.occupancy : item_s1.occupancy - target_q;
		dist_best = (old_st.best_occupancy < target_q) ?
			target_q - old_st.best_occupancy : old_st.best_occupancy - target_q;
		strim_sat = (CNT_W'(item_s1.start_trim) > cnt_m1) ?
			cnt_m1[TRIM_W-1:0] : item_s1.start_trim;
		wl_new    = below ? CNT_W'(old_st.current_trim) : old_st.window_low;
		wh_new    = below ? old_st.window_high : CNT_W'(old_st.current_trim);
		win_sum   = {1'b0, wl_new} + {1'b0, wh_new};
		new_st    = old_st;
		nxt       = '0;

		if (item_s1.cmd == CMD_START) begin
			new_st.window_low     = '0;
			new_st.window_high    = cnt;
			new_st.current_trim   = strim_sat;
			new_st.best_code      = strim_sat;
			new_st.best_occupancy = (target_q < OCC_HALF) ? OCC_FULL : OCC_ZERO;
		end else begin
			if (dist_new <= dist_best) begin
				new_st.best_occupancy = item_s1.occupancy;
				new_st.best_code      = old_st.current_trim;
			end
			new_st.window_low  = wl_new;
			new_st.window_high = wh_new;
			if (!step_mode_q) begin
				nxt = win_sum[CNT_W:1];
			end else if (below) begin
				nxt = CNT_W'(old_st.current_trim) + CNT_W'(1);
			end else if (old_st.current_trim == '0) begin
				nxt = '0;
			end else begin
				nxt = CNT_W'(old_st.current_trim) - CNT_W'(1);
			end
			if (nxt > cnt_m1) begin
				nxt = cnt_m1;
			end
			new_st.current_trim = nxt[TRIM_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_adv) begin
			out_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid && s1_adv) begin
			out_data.out_pixel_addr <= item_s1.pixel_addr;
			out_data.next_trim      <= new_st.current_trim;
			out_data.best_trim      <= new_st.best_code;
		end
	end

	// a transfer never lands on a stalled stage 1
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!s1_valid || s1_adv))
		else $error("input transfer while stage 1 is stalled");

	// a retiring item always reaches the output register
	a_retire_out: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && s1_adv) |=> out_valid)
		else $error("retired item did not reach the output");

	// a stalled stage 1 keeps its item
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !s1_adv) |=> (s1_valid && $stable(item_s1)))
		else $error("stage 1 item lost while stalled");

	// the forwarding register tracks the last write back
	a_fwd_track: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && s1_adv) |=> (fwd_valid_q && fwd_idx_q == $past(idx_s1)))
		else $error("forwarding register out of step with write back");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench for the per-pixel trim search engine: directed and random command streams,
// checked against a behavioral tracker of per-pixel search state. Depends on pts_pkg
// and pixel_trim_successive_approx_top.

import pts_pkg::*;

// Tracks every pixel's search state and the configuration, and holds the expected results.
class trim_search_tracker;
	bit [CNT_W-1:0]  win_lo   [PIXELS];
	bit [CNT_W-1:0]  win_hi   [PIXELS];
	bit [TRIM_W-1:0] cur_trim [PIXELS];
	bit [TRIM_W-1:0] best_code[PIXELS];
	bit [OCC_W-1:0]  best_occ [PIXELS];
	bit [OCC_W-1:0]  target;
	bit [CNT_W-1:0]  trim_cnt;
	bit              step_mode;
	out_item_t       expected_trims[$];
	int              mismatches;

	function new();
		target     = OCC_HALF;
		trim_cnt   = CNT_MAX;
		step_mode  = 1'b0;
		mismatches = 0;
	endfunction

	function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_TARGET:    target = val[OCC_W-1:0];
			REG_TRIM_CNT:  trim_cnt = val[CNT_W-1:0];
			REG_STEP_MODE: step_mode = val[0];
			default: ;
		endcase
	endfunction

	function int dist_to_target(int v);
		int t;
		t = int'(target);
		return (v >= t) ? v - t : t - v;
	endfunction

	// Apply one accepted command and queue the result it must produce.
	function void note_command(in_item_t it);
		int        cnt;
		int        p;
		int        occ;
		int        cur;
		int        nxt;
		bit        below;
		out_item_t res;
		cnt = int'(trim_cnt);
		if (cnt < 2) cnt = 2;
		if (cnt > MAX_TRIM_CODES) cnt = MAX_TRIM_CODES;
		p = int'(it.pixel_addr) % PIXELS;
		if (it.cmd == CMD_START) begin
			cur = int'(it.start_trim);
			if (cur > cnt - 1) cur = cnt - 1;
			win_lo[p]    = '0;
			win_hi[p]    = CNT_W'(cnt);
			cur_trim[p]  = TRIM_W'(cur);
			best_code[p] = TRIM_W'(cur);
			best_occ[p]  = (target < OCC_HALF) ? OCC_FULL : OCC_ZERO;
		end else begin
			occ   = int'(it.occupancy);
			cur   = int'(cur_trim[p]);
			below = occ < int'(target);
			// ties go to the newer measurement
			if (dist_to_target(occ) <= dist_to_target(int'(best_occ[p]))) begin
				best_occ[p]  = OCC_W'(occ);
				best_code[p] = TRIM_W'(cur);
			end
			if (below) win_lo[p] = CNT_W'(cur);
			else win_hi[p] = CNT_W'(cur);
			if (!step_mode) nxt = (int'(win_lo[p]) + int'(win_hi[p])) / 2;
			else if (below) nxt = cur + 1;
			else nxt = (cur == 0) ? 0 : cur - 1;
			if (nxt > cnt - 1) nxt = cnt - 1;
			cur_trim[p] = TRIM_W'(nxt);
		end
		res.out_pixel_addr = it.pixel_addr;
		res.next_trim      = cur_trim[p];
		res.best_trim      = best_code[p];
		expected_trims = {expected_trims, res};
	endfunction

	// Compare one result transfer with the oldest expectation.
	function void check_result(out_item_t got);
		out_item_t exp_res;
		if (expected_trims.size() == 0) begin
			$error("result for pixel %0d with no command pending", got.out_pixel_addr);
			mismatches++;
			return;
		end
		exp_res = expected_trims.pop_front();
		if (got.out_pixel_addr !== exp_res.out_pixel_addr) begin
			$error("out_pixel_addr: expected %0d, got %0d",
				exp_res.out_pixel_addr, got.out_pixel_addr);
			mismatches++;
		end
		if (got.next_trim !== exp_res.next_trim) begin
			$error("next_trim: expected %0d, got %0d (pixel %0d)",
				exp_res.next_trim, got.next_trim, exp_res.out_pixel_addr);
			mismatches++;
		end
		if (got.best_trim !== exp_res.best_trim) begin
			$error("best_trim: expected %0d, got %0d (pixel %0d)",
				exp_res.best_trim, got.best_trim, exp_res.out_pixel_addr);
			mismatches++;
		end
	endfunction
endclass

module tb;
	localparam int HALF_PERIOD = 4;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES      = 10;
	localparam int PHASE_CMDS  = 118;
	localparam int POOL_SIZE   = 16;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx   = REG_TARGET;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_item_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_data;

	trim_search_tracker tracker = new();
	bit                 started[PIXELS];
	bit                 steady_flow;
	int                 quiet_cycles;
	logic [15:0]        pool[POOL_SIZE];
	logic [15:0]        last_addr;

	pixel_trim_successive_approx_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// mostly short pauses, a few long ones, none in a steady stretch
	function automatic int pick_gap();
		int r;
		if (steady_flow) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// Hold one command on the input until it transfers.
	task automatic send_cmd(cmd_t c, logic [15:0] addr, logic [TRIM_W-1:0] trim,
			logic [OCC_W-1:0] occ);
		in_item_t it;
		int       gap;
		it.cmd        = c;
		it.pixel_addr = addr;
		it.start_trim = trim;
		it.occupancy  = occ;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		tracker.note_command(it);
		if (c == CMD_START) started[addr] = 1'b1;
		last_addr = addr;
	endtask

	// Drop valid and hold until every pending result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.expected_trims.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_regs(logic [OCC_W-1:0] tgt, logic [CNT_W-1:0] cnt, logic mode);
		cfg_we    <= 1'b1;
		cfg_idx   <= REG_TARGET;
		cfg_wdata <= CFG_DATA_W'(tgt);
		@(posedge clk);
		tracker.set_reg(REG_TARGET, CFG_DATA_W'(tgt));
		cfg_idx   <= REG_TRIM_CNT;
		cfg_wdata <= CFG_DATA_W'(cnt);
		@(posedge clk);
		tracker.set_reg(REG_TRIM_CNT, CFG_DATA_W'(cnt));
		cfg_idx   <= REG_STEP_MODE;
		cfg_wdata <= CFG_DATA_W'(mode);
		@(posedge clk);
		tracker.set_reg(REG_STEP_MODE, CFG_DATA_W'(mode));
		cfg_we <= 1'b0;
	endtask

	// Occupancy biased toward the target so the search converges, with extremes mixed in.
	function automatic logic [OCC_W-1:0] pick_occupancy();
		int t;
		int v;
		t = int'(tracker.target);
		case ($urandom_range(0, 9))
			0: v = 0;
			1: v = 65535;
			2: v = t;
			3, 4: v = $urandom_range(0, 65535);
			default: begin
				v = t + $urandom_range(0, 1024) - 512;
				if (v < 0) v = 0;
				if (v > 65535) v = 65535;
			end
		endcase
		return OCC_W'(v);
	endfunction

	// One random command: mostly measurements on started pool pixels, some restarts and noise.
	task automatic send_random_cmd();
		int          r;
		logic [15:0] addr;
		r    = $urandom_range(0, 99);
		addr = pool[$urandom_range(0, POOL_SIZE - 1)];
		if (r < 12) begin
			send_cmd(CMD_START, addr, TRIM_W'($urandom), OCC_W'($urandom));
		end else if (r < 17) begin
			send_cmd(CMD_START, 16'($urandom), TRIM_W'($urandom), OCC_W'($urandom));
		end else if (r < 45 && started[last_addr]) begin
			send_cmd(CMD_MEASURE, last_addr, TRIM_W'($urandom), pick_occupancy());
		end else if (started[addr]) begin
			send_cmd(CMD_MEASURE, addr, TRIM_W'($urandom), pick_occupancy());
		end else begin
			send_cmd(CMD_START, addr, TRIM_W'($urandom), OCC_W'($urandom));
		end
	endtask

	// Receiver: ready runs broken by stalls, held high in steady stretches.
	initial begin
		int run;
		@(posedge clk iff arst_n);
		forever begin
			if (steady_flow) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				out_ready <= 1'b1;
				run = $urandom_range(1, 12);
				repeat (run) @(posedge clk);
				run = pick_gap();
				if (run > 0) begin
					out_ready <= 1'b0;
					repeat (run) @(posedge clk);
				end
			end
		end
	end

	// Check every result transfer.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) tracker.check_result(out_data);
	end

	// End the run when nothing transfers for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		steady_flow  = 1'b0;
		quiet_cycles = 0;
		last_addr    = '0;
		pool[0] = 16'd0;
		pool[1] = 16'hFFFF;
		pool[2] = 16'd7;
		for (int i = 3; i < POOL_SIZE; i++) pool[i] = 16'($urandom);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: tie with the reset record, exact target, occupancy above one
		send_cmd(CMD_START, 16'd0, 5'd0, 16'd0);
		send_cmd(CMD_START, 16'hFFFF, 5'd31, 16'hFFFF);
		send_cmd(CMD_MEASURE, 16'hFFFF, 5'd0, 16'd32768);
		send_cmd(CMD_MEASURE, 16'hFFFF, 5'd31, 16'd16384);
		send_cmd(CMD_MEASURE, 16'd0, 5'd0, 16'd0);
		send_cmd(CMD_MEASURE, 16'd0, 5'd31, 16'hFFFF);
		send_cmd(CMD_MEASURE, 16'd0, 5'd0, 16'd16383);
		send_cmd(CMD_START, 16'h5555, 5'd10, 16'h5555);
		send_cmd(CMD_MEASURE, 16'h5555, 5'd21, 16'd16385);
		send_cmd(CMD_START, 16'hAAAA, 5'd21, 16'hAAAA);
		send_cmd(CMD_MEASURE, 16'hAAAA, 5'd10, 16'd0);
		drain();

		// low target, short count, step mode: start trim and step saturation
		program_regs(16'd100, 6'd3, 1'b1);
		send_cmd(CMD_START, 16'd7, 5'd31, 16'd0);
		send_cmd(CMD_MEASURE, 16'd7, 5'd0, 16'd0);
		send_cmd(CMD_MEASURE, 16'd7, 5'd0, 16'd0);
		send_cmd(CMD_MEASURE, 16'd7, 5'd0, 16'hFFFF);
		send_cmd(CMD_MEASURE, 16'd0, 5'd0, 16'd100);
		send_cmd(CMD_MEASURE, 16'hFFFF, 5'd0, 16'd0);
		send_cmd(CMD_MEASURE, 16'hAAAA, 5'd0, 16'd200);
		drain();

		// count below range clamps to two; old windows saturate the midpoint
		program_regs(16'd16384, 6'd0, 1'b0);
		send_cmd(CMD_MEASURE, 16'h5555, 5'd0, 16'd40000);
		send_cmd(CMD_START, 16'd3, 5'd5, 16'd0);
		send_cmd(CMD_MEASURE, 16'd3, 5'd0, 16'd16384);
		drain();

		// random phases, one setting each, extremes first
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: program_regs(16'd16384, 6'd32, 1'b0);
				1: program_regs(16'd100, 6'd8, 1'b1);
				2: program_regs(16'd0, 6'd2, 1'b0);
				3: program_regs(16'hFFFF, 6'd63, 1'b1);
				4: program_regs(16'd32768, 6'd1, 1'b0);
				5: program_regs(16'd16383, 6'd0, 1'b1);
				6: program_regs(16'd40000, 6'd33, 1'b0);
				7: program_regs(16'($urandom), 6'($urandom), 1'($urandom));
				8: program_regs(16'($urandom_range(0, 32768)), 6'd4, 1'b0);
				default: program_regs(16'($urandom_range(0, 32768)), 6'd32, 1'b1);
			endcase
			steady_flow = (ph == 2) || (ph == 6) || ($urandom_range(0, 3) == 0);
			for (int i = 0; i < PHASE_CMDS; i++) send_random_cmd();
			drain();
			steady_flow = 1'b0;
		end

		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.expected_trims.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
